>>> rtl/core/tmcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcg_pkg
// Shared types and constants of the text mode character generator.
// ----------------------------------------------------------------------------
package tmcg_pkg;

  localparam int MEM_ADDR_W  = 17;
  localparam int MEM_DATA_W  = 8;
  localparam int PIX_X_W     = 10;
  localparam int PIX_Y_W     = 9;
  localparam int COLOR_W     = 24;
  localparam int CFG_DATA_W  = 24;
  localparam int TEXT_BASE_W = 17;

  localparam int CELL_WIDTH   = 8;
  localparam int COL_W        = $clog2(CELL_WIDTH);
  localparam int GLYPH_STRIDE = 32;
  localparam int GLYPH_ROW_W  = $clog2(GLYPH_STRIDE);

  localparam logic [TEXT_BASE_W-1:0] TEXT_BASE_RESET = 17'h18000;
  localparam logic [COLOR_W-1:0]     LIT_RESET       = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0]     DARK_RESET      = 24'h000000;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    REG_TEXT_BASE  = 2'd0,
    REG_LIT_COLOR  = 2'd1,
    REG_DARK_COLOR = 2'd2
  } reg_idx_e;

  // pixel position and glyph lookup info carried down the pipeline
  typedef struct packed {
    logic [PIX_X_W-1:0]     x;
    logic [PIX_Y_W-1:0]     y;
    logic [COL_W-1:0]       col;
    logic [GLYPH_ROW_W-1:0] glyph_row;
    logic                   last;
  } tmcg_pix_t;

endpackage

>>> rtl/core/tmcg_vram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcg_vram
// Video memory: one write port, two registered read ports, clearing pass
// after reset.
// ----------------------------------------------------------------------------
module tmcg_vram import tmcg_pkg::*; #(
  parameter int VRAM_BYTES = 131072,
  localparam int AW = $clog2(VRAM_BYTES)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [MEM_DATA_W-1:0] wdata_i,
  input  logic                  ra_en_i,
  input  logic [AW-1:0]         ra_addr_i,
  output logic [MEM_DATA_W-1:0] ra_data_o,
  input  logic                  rb_en_i,
  input  logic [AW-1:0]         rb_addr_i,
  output logic [MEM_DATA_W-1:0] rb_data_o,
  output logic                  busy_o
);

  logic [MEM_DATA_W-1:0] mem [VRAM_BYTES];

  logic          clr_q, clr_d;
  logic [AW-1:0] clr_addr_q, clr_addr_d;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [MEM_DATA_W-1:0] mem_wdata;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(VRAM_BYTES - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign mem_we    = clr_q | we_i;
  assign mem_waddr = clr_q ? clr_addr_q : waddr_i;
  assign mem_wdata = clr_q ? '0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ra_en_i) begin
      ra_data_o <= mem[ra_addr_i];
    end
    if (rb_en_i) begin
      rb_data_o <= mem[rb_addr_i];
    end
  end

  assign busy_o = clr_q;

endmodule

>>> rtl/core/tmcg_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcg_scan
// Raster position counters and character cell address generation.
// ----------------------------------------------------------------------------
module tmcg_scan import tmcg_pkg::*; #(
  parameter int VRAM_BYTES   = 131072,
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 25,
  parameter int GLYPH_ROWS   = 16,
  localparam int AW = $clog2(VRAM_BYTES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          advance_i,
  input  logic [AW-1:0] text_base_i,
  output logic [AW-1:0] char_addr_o,
  output tmcg_pix_t     pix_o
);

  localparam int FRAME_W = TEXT_COLUMNS * CELL_WIDTH;
  localparam int FRAME_H = TEXT_ROWS * GLYPH_ROWS;
  localparam int XW      = $clog2(FRAME_W);
  localparam int YW      = $clog2(FRAME_H);
  localparam int GW      = $clog2(GLYPH_ROWS);
  localparam int OW      = $clog2(TEXT_COLUMNS * TEXT_ROWS);
  localparam int SW      = AW + 1;

  logic [XW-1:0] x_q, x_d;
  logic [YW-1:0] y_q, y_d;
  logic [GW-1:0] g_q, g_d;
  logic [OW-1:0] off_q, off_d;

  logic          x_end, y_end, g_end;
  logic [SW-1:0] sum;

  assign x_end = (x_q == XW'(FRAME_W - 1));
  assign y_end = (y_q == YW'(FRAME_H - 1));
  assign g_end = (g_q == GW'(GLYPH_ROWS - 1));

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    g_d   = g_q;
    off_d = off_q;
    if (advance_i) begin
      if (x_end) begin
        x_d = '0;
        if (y_end) begin
          y_d   = '0;
          g_d   = '0;
          off_d = '0;
        end else begin
          y_d = y_q + 1'b1;
          if (g_end) begin
            g_d   = '0;
            off_d = off_q + 1'b1;
          end else begin
            g_d   = g_q + 1'b1;
            off_d = off_q - OW'(TEXT_COLUMNS - 1);
          end
        end
      end else begin
        x_d = x_q + 1'b1;
        if (x_q[COL_W-1:0] == COL_W'(CELL_WIDTH - 1)) begin
          off_d = off_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      g_q   <= '0;
      off_q <= '0;
    end else begin
      x_q   <= x_d;
      y_q   <= y_d;
      g_q   <= g_d;
      off_q <= off_d;
    end
  end

  // two bytes per cell, base already reduced below memory size
  assign sum         = SW'({off_q, 1'b0}) + SW'(text_base_i);
  assign char_addr_o = (sum >= SW'(VRAM_BYTES)) ? AW'(sum - SW'(VRAM_BYTES)) : AW'(sum);

  assign pix_o.x         = PIX_X_W'(x_q);
  assign pix_o.y         = PIX_Y_W'(y_q);
  assign pix_o.col       = x_q[COL_W-1:0];
  assign pix_o.glyph_row = GLYPH_ROW_W'(g_q);
  assign pix_o.last      = x_end & y_end;

endmodule

>>> rtl/core/text_mode_character_generator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_character_generator_core
// Text mode scan-out: video memory writes and one pixel per tick item,
// character byte and glyph row fetched from the same video memory.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                 | payload
//  in       | in  | in_valid_i / in_stall_o   | opcode_i, mem_address_i, mem_data_i
//  out      | out | out_valid_o / out_stall_i | pixel_x_o, pixel_y_o, pixel_color_o,
//           |     |                           | frame_last_o
//  cfg      | in  | cfg_we_i                  | cfg_index_i, cfg_data_i
//
//  one item per cycle while in_stall_o is low; a taken tick's pixel goes through
//  character read, then glyph read, then color select into the output register
//  after reset the memory is cleared to zero with in_stall_o high; after that,
//  in_stall_o rises only when a tick waits for its glyph read behind a stalled output
// ----------------------------------------------------------------------------
module text_mode_character_generator_core import tmcg_pkg::*; #(
  parameter int VRAM_BYTES   = 131072,
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 25,
  parameter int GLYPH_ROWS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  opcode_i,
  input  logic [MEM_ADDR_W-1:0] mem_address_i,
  input  logic [MEM_DATA_W-1:0] mem_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_X_W-1:0]    pixel_x_o,
  output logic [PIX_Y_W-1:0]    pixel_y_o,
  output logic [COLOR_W-1:0]    pixel_color_o,
  output logic                  frame_last_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = $clog2(VRAM_BYTES);
  localparam int WW = ((AW > MEM_ADDR_W) ? AW : MEM_ADDR_W) + 1;
  localparam logic [AW-1:0] BASE_RST = AW'(TEXT_BASE_RESET % VRAM_BYTES);

  logic [AW-1:0]      text_base_q;
  logic [COLOR_W-1:0] lit_q, dark_q;
  logic [WW-1:0]      base_ext, wr_ext;
  logic [AW-1:0]      base_red, wr_addr;

  logic busy;
  logic in_acc, tick_acc, wr_acc;
  logic en2, en3;

  logic      s1_v_q, s2_v_q, out_v_q;
  tmcg_pix_t scan_pix, s1_pix_q, s2_pix_q;

  logic [AW-1:0]         char_addr, glyph_addr;
  logic [MEM_DATA_W-1:0] char_data, glyph_data;

  // config, text base kept reduced modulo memory size
  assign base_ext = WW'(cfg_data_i[TEXT_BASE_W-1:0]);
  assign base_red = (base_ext >= WW'(VRAM_BYTES)) ? AW'(base_ext - WW'(VRAM_BYTES))
                                                  : AW'(base_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_base_q <= BASE_RST;
      lit_q       <= LIT_RESET;
      dark_q      <= DARK_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_TEXT_BASE:  text_base_q <= base_red;
        REG_LIT_COLOR:  lit_q       <= cfg_data_i[COLOR_W-1:0];
        REG_DARK_COLOR: dark_q      <= cfg_data_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign en3        = ~out_v_q | ~out_stall_i;
  assign en2        = ~s2_v_q | en3;
  assign in_stall_o = busy | (s1_v_q & ~en2);
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign tick_acc   = in_acc & (opcode_i == OP_TICK);
  assign wr_acc     = in_acc & (opcode_i == OP_WRITE);

  assign wr_ext  = WW'(mem_address_i);
  assign wr_addr = (wr_ext >= WW'(VRAM_BYTES)) ? AW'(wr_ext - WW'(VRAM_BYTES))
                                               : AW'(wr_ext);

  tmcg_scan #(
    .VRAM_BYTES  (VRAM_BYTES),
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS),
    .GLYPH_ROWS  (GLYPH_ROWS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (tick_acc),
    .text_base_i(text_base_q),
    .char_addr_o(char_addr),
    .pix_o      (scan_pix)
  );

  assign glyph_addr = AW'({char_data, s1_pix_q.glyph_row});

  tmcg_vram #(
    .VRAM_BYTES(VRAM_BYTES)
  ) u_vram (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (wr_acc),
    .waddr_i  (wr_addr),
    .wdata_i  (mem_data_i),
    .ra_en_i  (tick_acc),
    .ra_addr_i(char_addr),
    .ra_data_o(char_data),
    .rb_en_i  (en2 & s1_v_q),
    .rb_addr_i(glyph_addr),
    .rb_data_o(glyph_data),
    .busy_o   (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (~s1_v_q | en2) begin
        s1_v_q <= tick_acc;
      end
      if (en2) begin
        s2_v_q <= s1_v_q;
      end
      if (en3) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_pix_q <= scan_pix;
    end
    if (en2 & s1_v_q) begin
      s2_pix_q <= s1_pix_q;
    end
    if (en3 & s2_v_q) begin
      pixel_x_o     <= s2_pix_q.x;
      pixel_y_o     <= s2_pix_q.y;
      frame_last_o  <= s2_pix_q.last;
      pixel_color_o <= glyph_data[COL_W'(CELL_WIDTH - 1) - s2_pix_q.col] ? lit_q : dark_q;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

>>> rtl/core/tmcg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcg_checker
// Port level checks on the pixel output of the character generator.
// ----------------------------------------------------------------------------
module tmcg_checker import tmcg_pkg::*; #(
  parameter int TEXT_COLUMNS = 80,
  parameter int TEXT_ROWS    = 25,
  parameter int GLYPH_ROWS   = 16
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [PIX_X_W-1:0] pixel_x_o,
  input logic [PIX_Y_W-1:0] pixel_y_o,
  input logic [COLOR_W-1:0] pixel_color_o,
  input logic               frame_last_o
);

  localparam logic [PIX_X_W-1:0] LAST_X = PIX_X_W'(TEXT_COLUMNS * CELL_WIDTH - 1);
  localparam logic [PIX_Y_W-1:0] LAST_Y = PIX_Y_W'(TEXT_ROWS * GLYPH_ROWS - 1);

  logic out_acc;
  assign out_acc = out_valid_o & ~out_stall_i;

  // stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(pixel_color_o) && $stable(frame_last_o))
    else $error("stalled pixel item changed");

  // last flag only at the final coordinate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> pixel_x_o == LAST_X && pixel_y_o == LAST_Y)
    else $error("frame_last on wrong coordinate");

  // pixels within a line follow in raster order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && pixel_x_o != LAST_X) ##1 out_valid_o |->
      pixel_x_o == $past(pixel_x_o) + 1'b1 && pixel_y_o == $past(pixel_y_o))
    else $error("pixel out of raster order");

  // scan restarts after the last pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && frame_last_o) ##1 out_valid_o |-> pixel_x_o == '0 && pixel_y_o == '0)
    else $error("scan did not restart at origin");

endmodule

bind text_mode_character_generator_core tmcg_checker #(
  .TEXT_COLUMNS(TEXT_COLUMNS),
  .TEXT_ROWS   (TEXT_ROWS),
  .GLYPH_ROWS  (GLYPH_ROWS)
) u_tmcg_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks text_mode_character_generator_core against its own model of video
// memory and the raster scan. A short directed opening, three phases of
// random write and tick items under different register settings with random
// stalls on both channels, then a last stretch of items at full rate.
// ----------------------------------------------------------------------------
module testbench;
  import tmcg_pkg::*;

  localparam int VRAM_BYTES    = 131072;
  localparam int TEXT_COLUMNS  = 80;
  localparam int TEXT_ROWS     = 25;
  localparam int GLYPH_ROWS    = 16;
  localparam int CELL_BYTES    = 2;
  localparam int FRAME_W       = TEXT_COLUMNS * CELL_WIDTH;
  localparam int FRAME_H       = TEXT_ROWS * GLYPH_ROWS;
  localparam int FRAME_PIXELS  = FRAME_W * FRAME_H;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_MAX    = 10;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    opcode_e                op;
    logic [MEM_ADDR_W-1:0]  addr;
    logic [MEM_DATA_W-1:0]  data;
  } vram_item_t;

  typedef struct packed {
    logic [PIX_X_W-1:0]  x;
    logic [PIX_Y_W-1:0]  y;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } pixel_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  opcode_i      = 1'b0;
  logic [MEM_ADDR_W-1:0] mem_address_i = '0;
  logic [MEM_DATA_W-1:0] mem_data_i    = '0;
  logic                  out_stall_i   = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [1:0]            cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [PIX_X_W-1:0]    pixel_x_o;
  logic [PIX_Y_W-1:0]    pixel_y_o;
  logic [COLOR_W-1:0]    pixel_color_o;
  logic                  frame_last_o;

  // model state
  bit   [7:0]             vram_model [VRAM_BYTES];
  logic [PIX_X_W-1:0]     scan_x      = '0;
  logic [PIX_Y_W-1:0]     scan_y      = '0;
  logic [TEXT_BASE_W-1:0] text_base_m = TEXT_BASE_RESET;
  logic [COLOR_W-1:0]     lit_m       = LIT_RESET;
  logic [COLOR_W-1:0]     dark_m      = DARK_RESET;

  // stimulus planning: memory and scan position after every queued item
  bit [7:0] plan_vram [VRAM_BYTES];
  int       plan_pos = 0;

  vram_item_t stim_items[$];
  pixel_t     pending_pixels[$];
  int         items_queued = 0;
  int         items_taken  = 0;
  bit         idling_on    = 1'b1;
  bit         in_taken     = 1'b0;
  int         in_gap       = 0;
  int         out_gap      = 0;
  int         mismatches   = 0;
  int         cycle_count  = 0;

  text_mode_character_generator_core #(
    .VRAM_BYTES  (VRAM_BYTES),
    .TEXT_COLUMNS(TEXT_COLUMNS),
    .TEXT_ROWS   (TEXT_ROWS),
    .GLYPH_ROWS  (GLYPH_ROWS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .mem_address_i(mem_address_i),
    .mem_data_i   (mem_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_color_o(pixel_color_o),
    .frame_last_o (frame_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [MEM_ADDR_W-1:0] char_address(int x, int y,
                                                         logic [TEXT_BASE_W-1:0] base);
    int unsigned addr;
    addr = base + ((y / GLYPH_ROWS) * TEXT_COLUMNS + x / CELL_WIDTH) * CELL_BYTES;
    return MEM_ADDR_W'(addr % VRAM_BYTES);
  endfunction

  task automatic scan_out_item(vram_item_t item);
    pixel_t      px;
    logic [7:0]  ch;
    logic [7:0]  glyph;
    int unsigned glyph_addr;
    if (item.op == OP_WRITE) begin
      vram_model[item.addr] = item.data;
    end else begin
      ch = vram_model[char_address(int'(scan_x), int'(scan_y), text_base_m)];
      glyph_addr = (int'(ch) * GLYPH_STRIDE + int'(scan_y) % GLYPH_ROWS) % VRAM_BYTES;
      glyph = vram_model[glyph_addr];
      px.x = scan_x;
      px.y = scan_y;
      px.color = glyph[CELL_WIDTH - 1 - int'(scan_x) % CELL_WIDTH] ? lit_m : dark_m;
      px.last = (scan_x == FRAME_W - 1) && (scan_y == FRAME_H - 1);
      pending_pixels.push_back(px);
      if (scan_x == FRAME_W - 1) begin
        scan_x = '0;
        scan_y = (scan_y == FRAME_H - 1) ? '0 : scan_y + 1'b1;
      end else begin
        scan_x = scan_x + 1'b1;
      end
    end
  endtask

  task automatic queue_write(logic [MEM_ADDR_W-1:0] addr, logic [MEM_DATA_W-1:0] data);
    vram_item_t item;
    item.op = OP_WRITE;
    item.addr = addr;
    item.data = data;
    plan_vram[addr] = data;
    stim_items.push_back(item);
    items_queued++;
  endtask

  task automatic queue_ticks(int n);
    vram_item_t item;
    repeat (n) begin
      item.op = OP_TICK;
      item.addr = MEM_ADDR_W'($urandom_range(0, VRAM_BYTES - 1));
      item.data = MEM_DATA_W'($urandom_range(0, 255));
      stim_items.push_back(item);
      items_queued++;
      plan_pos = (plan_pos + 1) % FRAME_PIXELS;
    end
  endtask

  // character byte of the cell holding pixel pos
  task automatic queue_cell_char(int pos, logic [7:0] data);
    queue_write(char_address(pos % FRAME_W, pos / FRAME_W, text_base_m), data);
  endtask

  // glyph row that pixel pos will fetch, given the planned character
  task automatic queue_glyph_row(int pos, logic [7:0] data);
    int         y;
    logic [7:0] ch;
    y = pos / FRAME_W;
    ch = plan_vram[char_address(pos % FRAME_W, y, text_base_m)];
    queue_write(MEM_ADDR_W'(int'(ch) * GLYPH_STRIDE + y % GLYPH_ROWS), data);
  endtask

  task automatic queue_random_items(int n);
    int pick;
    int pos;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      pos = (plan_pos + $urandom_range(0, 24)) % FRAME_PIXELS;
      if (pick < 45) begin
        queue_ticks(1);
      end else if (pick < 65) begin
        queue_cell_char(pos, 8'($urandom_range(0, 255)));
      end else if (pick < 85) begin
        queue_glyph_row(pos, 8'($urandom_range(0, 255)));
      end else begin
        queue_write(MEM_ADDR_W'($urandom_range(0, VRAM_BYTES - 1)),
                    8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_TEXT_BASE:  text_base_m = value[TEXT_BASE_W-1:0];
      REG_LIT_COLOR:  lit_m = value[COLOR_W-1:0];
      REG_DARK_COLOR: dark_m = value[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (items_taken != items_queued || pending_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // input driver
  always @(negedge clk_i) begin
    vram_item_t item;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (stim_items.size() != 0) begin
        if (idling_on && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 18) - 1;
          in_valid_i <= 1'b0;
        end else begin
          item = stim_items.pop_front();
          in_valid_i    <= 1'b1;
          opcode_i      <= item.op;
          mem_address_i <= item.addr;
          mem_data_i    <= item.data;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stall driver
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall_i <= 1'b1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 18) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    vram_item_t item;
    pixel_t     got;
    pixel_t     want;
    in_taken = in_valid_i && !in_stall_o;
    if (in_taken) begin
      item.op = opcode_e'(opcode_i);
      item.addr = mem_address_i;
      item.data = mem_data_i;
      scan_out_item(item);
      items_taken++;
    end
    if (out_valid_o && !out_stall_i) begin
      got.x = pixel_x_o;
      got.y = pixel_y_o;
      got.color = pixel_color_o;
      got.last = frame_last_o;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected pixel: x=%0d y=%0d color=%06h last=%0b",
                   got.x, got.y, got.color, got.last);
      end else begin
        want = pending_pixels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("pixel mismatch: expected x=%0d y=%0d color=%06h last=%0b,",
                     want.x, want.y, want.color, want.last,
                     " got x=%0d y=%0d color=%06h last=%0b",
                     got.x, got.y, got.color, got.last);
        end
      end
    end
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("text_mode_character_generator_core test failed");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: cell 0 holds 'A', cell 1 gets 0xff just before its fetch,
    // cell 2 has only its attribute byte set
    queue_write(TEXT_BASE_RESET, 8'h41);
    queue_write(17'h00820, 8'hFF);
    queue_write(17'h00000, 8'hA5);
    queue_write(MEM_ADDR_W'(TEXT_BASE_RESET + 5), 8'hFF);
    queue_ticks(8);
    queue_write(MEM_ADDR_W'(TEXT_BASE_RESET + 2), 8'hFF);
    queue_write(17'h01FE0, 8'h81);
    queue_ticks(8);
    queue_write(17'h1FFFF, 8'h00);
    queue_ticks(4);
    wait_idle();

    // cell array wraps past the top of memory, colors swapped
    write_reg(REG_TEXT_BASE, 24'h01FFFF);
    write_reg(REG_LIT_COLOR, 24'h000000);
    write_reg(REG_DARK_COLOR, 24'hFFFFFF);
    queue_random_items(110);
    wait_idle();

    // cell array on top of the font, upper data bits ignored
    write_reg(REG_TEXT_BASE, 24'hFE0000);
    write_reg(REG_LIT_COLOR, 24'($urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_DARK_COLOR, 24'($urandom_range(0, 24'hFFFFFF)));
    queue_random_items(110);
    wait_idle();

    write_reg(REG_TEXT_BASE, 24'($urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_LIT_COLOR, 24'($urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_DARK_COLOR, 24'($urandom_range(0, 24'hFFFFFF)));
    write_reg(REG_UNUSED, 24'($urandom_range(0, 24'hFFFFFF)));
    queue_random_items(110);
    wait_idle();

    // last stretch at full rate with no idling on either side
    idling_on = 1'b0;
    write_reg(REG_TEXT_BASE, CFG_DATA_W'(TEXT_BASE_RESET));
    write_reg(REG_LIT_COLOR, LIT_RESET);
    write_reg(REG_DARK_COLOR, DARK_RESET);
    queue_random_items(60);
    wait_idle();

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("text_mode_character_generator_core test passed");
    end else begin
      $display("text_mode_character_generator_core test failed");
    end
    $finish;
  end

endmodule
